// ===== rtl/core/sfd_pkg.sv =====
// Shared types, codes and the CRC-16 byte step for the stuffed frame decoder.
// No dependencies; every other file in rtl/core imports this package.
package sfd_pkg;

    // Line control characters
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_SUBST = 8'h04;

    // CRC-16 (poly 0x1021, init 0, MSB first)
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [7:0] PACKET_LENGTH_RESET = 8'd72;
    localparam logic [7:0] BYTE_COUNT_MAX      = 8'd255;
    localparam logic [7:0] MIN_CRC_BYTES       = 8'd2;

    // What the front end found in one raw byte
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ETX  = 2'd2
    } sfd_kind_t;

    // Frame status reported at ETX
    typedef enum logic [1:0] {
        STATUS_GOOD = 2'd0,
        STATUS_CRC  = 2'd1,
        STATUS_LEN  = 2'd2
    } sfd_status_t;

    // One classified beat passed from front to back
    typedef struct packed {
        sfd_kind_t   kind;
        logic [7:0]  data;
    } sfd_item_t;

    // Fold one byte into the CRC, one bit per step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/sfd_if.sv =====
// Channel interfaces of the stuffed frame decoder: raw bytes, config writes, results.
// Depends on sfd_pkg.
interface sfd_byte_if;
    import sfd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_cfg_if;
    import sfd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] packet_length;

    modport source (output valid, output packet_length, input ready);
    modport sink   (input valid, input packet_length, output ready);
endinterface

interface sfd_res_if;
    import sfd_pkg::*;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       frame_done;
    logic [1:0] frame_status;

    modport source (output valid, output data_valid, output data_byte, output byte_index,
                    output frame_done, output frame_status, input ready);
    modport sink   (input valid, input data_valid, input data_byte, input byte_index,
                    input frame_done, input frame_status, output ready);
endinterface

// ===== rtl/core/stuffed_frame_decoder_crc_check_unit.sv =====
// Stuffed frame decoder with CRC-16 check: top level.
// Holds the packet length register; depends on sfd_pkg, sfd_if, sfd_front, sfd_queue, sfd_back.
//
// Channels: rx carries one raw line byte per beat; res returns exactly one result
// beat per rx beat, in order (data byte with index, frame end status, or all zero
// for framing bytes); cfg writes packet_length and is always ready.
// Bytes outside a frame are dropped until STX; SUBST escapes the next byte; an
// unescaped ETX closes the frame and reports good, CRC mismatch or length mismatch.
// Result path: a byte goes into the classification queue at the edge that accepts
// it and from there into the result register, which holds its result beat until taken.
// Throughput: one byte per cycle while the receiver takes results, set by the
// combinational CRC byte step in the back end.
// Reset: no frame open, count and CRC cleared, packet_length back to 72.
// Receiver stall: the result register holds; the two-entry queue absorbs the next
// bytes, and rx.ready drops only once the queue is full.
// Write packet_length only while no byte is outstanding.
module stuffed_frame_decoder_crc_check_unit
(
    input  logic        clk,
    input  logic        rst_n,
    sfd_byte_if.sink    rx,
    sfd_cfg_if.sink     cfg,
    sfd_res_if.source   res
);
    import sfd_pkg::*;

    logic [7:0] packet_length_reg;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    sfd_item_t  push_item;
    sfd_item_t  head_item;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            packet_length_reg <= PACKET_LENGTH_RESET;
        else if (cfg.valid)
            packet_length_reg <= cfg.packet_length;
    end

    sfd_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    sfd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    sfd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .packet_length (packet_length_reg),
        .q_not_empty   (q_not_empty),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .res           (res)
    );

endmodule

// ===== rtl/core/sfd_front.sv =====
// Front end: accepts raw line bytes, tracks framing and escapes, classifies each beat.
// Depends on sfd_pkg and sfd_byte_if.
module sfd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    sfd_byte_if.sink             rx,
    input  logic                 q_full,
    output logic                 q_push,
    output sfd_pkg::sfd_item_t   q_item
);
    import sfd_pkg::*;

    logic in_frame_reg, in_frame_next;
    logic escape_reg, escape_next;

    assign rx.ready = !q_full;
    assign q_push   = rx.valid && !q_full;

    // Classify the byte and work out the framing state after it
    always_comb
    begin
        in_frame_next = in_frame_reg;
        escape_next   = escape_reg;
        q_item.kind   = KIND_NONE;
        q_item.data   = rx.rx_byte;
        priority if (!in_frame_reg)
        begin
            if (rx.rx_byte == CH_STX)
                in_frame_next = 1'b1;
        end
        else if (escape_reg)
        begin
            escape_next = 1'b0;
            q_item.kind = KIND_DATA;
        end
        else if (rx.rx_byte == CH_ETX)
        begin
            in_frame_next = 1'b0;
            q_item.kind   = KIND_ETX;
        end
        else if (rx.rx_byte == CH_SUBST)
        begin
            escape_next = 1'b1;
        end
        else
        begin
            q_item.kind = KIND_DATA;
        end
    end

    // Framing state advances on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            escape_reg   <= 1'b0;
        end
        else if (q_push)
        begin
            in_frame_reg <= in_frame_next;
            escape_reg   <= escape_next;
        end
    end

endmodule

// ===== rtl/core/sfd_queue.sv =====
// Two-entry queue of classified beats between front and back end.
// Depends on sfd_pkg.
module sfd_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfd_pkg::sfd_item_t   push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output sfd_pkg::sfd_item_t   head_item
);
    import sfd_pkg::*;

    sfd_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_item = entry_reg[rd_ptr_reg];

    // Storage needs no reset
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/sfd_back.sv =====
// Back end: byte counting, delayed CRC-16, frame status and the result register.
// Depends on sfd_pkg and sfd_res_if.
module sfd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           packet_length,
    input  logic                 q_not_empty,
    input  sfd_pkg::sfd_item_t   q_item,
    output logic                 q_pop,
    sfd_res_if.source            res
);
    import sfd_pkg::*;

    // Frame state
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  older_reg, older_next;
    logic [7:0]  newer_reg, newer_next;

    // Result register
    logic        out_valid_reg;
    logic        data_valid_reg, data_valid_next;
    logic [7:0]  data_byte_reg, data_byte_next;
    logic [7:0]  index_reg, index_next;
    logic        done_reg, done_next;
    sfd_status_t status_reg, status_next;

    assign q_pop = q_not_empty && (!out_valid_reg || res.ready);

    // Work out one beat's result and the frame state after it
    always_comb
    begin
        count_next      = count_reg;
        crc_next        = crc_reg;
        older_next      = older_reg;
        newer_next      = newer_reg;
        data_valid_next = 1'b0;
        data_byte_next  = 8'h00;
        index_next      = 8'h00;
        done_next       = 1'b0;
        status_next     = STATUS_GOOD;
        unique case (q_item.kind)
            KIND_DATA:
            begin
                if (count_reg < packet_length)
                begin
                    data_valid_next = 1'b1;
                    data_byte_next  = q_item.data;
                    index_next      = count_reg;
                end
                // the older held byte enters the CRC once two newer ones exist
                if (count_reg >= MIN_CRC_BYTES)
                    crc_next = crc_byte(crc_reg, older_reg);
                older_next = newer_reg;
                newer_next = q_item.data;
                if (count_reg != BYTE_COUNT_MAX)
                    count_next = count_reg + 8'd1;
            end
            KIND_ETX:
            begin
                done_next = 1'b1;
                priority if (count_reg != packet_length)
                    status_next = STATUS_LEN;
                else if (count_reg < MIN_CRC_BYTES)
                    status_next = STATUS_CRC;
                else if ({newer_reg, older_reg} != crc_reg)
                    status_next = STATUS_CRC;
                else
                    status_next = STATUS_GOOD;
                count_next = 8'h00;
                crc_next   = CRC_INIT;
                older_next = 8'h00;
                newer_next = 8'h00;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Frame state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 8'h00;
            crc_reg       <= CRC_INIT;
            older_reg     <= 8'h00;
            newer_reg     <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
                older_reg <= older_next;
                newer_reg <= newer_next;
            end
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_valid_reg <= data_valid_next;
            data_byte_reg  <= data_byte_next;
            index_reg      <= index_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.data_valid   = data_valid_reg;
    assign res.data_byte    = data_byte_reg;
    assign res.byte_index   = index_reg;
    assign res.frame_done   = done_reg;
    assign res.frame_status = 2'(status_reg);

endmodule
